// ----- sv/rhsi_pkg.sv -----
// shared types, constants and step functions for the rgb to hsi pixel pipeline
package rhsi_pkg;

    localparam int CORDIC_STEPS = 16;
    // input stage, 16 rotation stages, one output stage
    localparam int NUM_STAGES   = CORDIC_STEPS + 2;
    localparam int LAST_STAGE   = NUM_STAGES - 1;
    localparam int DIV_FIRST    = 2;
    localparam int DIV_STEPS    = 8;

    typedef logic signed [29:0] t_xy;
    typedef logic signed [25:0] t_z;

    localparam t_z ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    localparam logic [16:0] SQRT3_Q16  = 17'd113512;
    localparam logic [15:0] RECIP3_Q17 = 16'd43691;
    localparam t_z          Z_90       = 26'sd5898240;
    localparam t_z          Z_180      = 26'sd11796480;
    localparam logic [25:0] H_360      = 26'd23592960;
    localparam logic [26:0] H_HALF     = 27'd65536;
    localparam logic [7:0]  HUE_MAX    = 8'd180;

    typedef struct packed {
        t_xy         x;
        t_xy         y;
        t_z          z;
        logic        gray;
        logic        bgt;
        logic [9:0]  sum;
        logic [7:0]  mn;
        logic [18:0] num;
        logic [10:0] den;
        logic [11:0] rem;
        logic [7:0]  quot;
        logic [7:0]  inten;
        logic [7:0]  hue;
        logic [7:0]  sat;
    } t_stage;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

    // one vectoring step, rotating y toward zero
    function automatic t_stage cordic_step(input t_stage s, input logic [3:0] i);
        t_stage r;
        t_xy    dx;
        t_xy    dy;
        r  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (s.y >= 0) begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + ATAN_TAB[i];
        end else begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - ATAN_TAB[i];
        end
        return r;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_stage div_step(input t_stage s, input logic [2:0] bit_idx);
        t_stage      r;
        logic [11:0] sh;
        r  = s;
        sh = {s.rem[10:0], s.num[{2'b00, bit_idx}]};
        if (sh >= {1'b0, s.den}) begin
            r.rem  = sh - {1'b0, s.den};
            r.quot = {s.quot[6:0], 1'b1};
        end else begin
            r.rem  = sh;
            r.quot = {s.quot[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- sv/rhsi_pipe_ctrl.sv -----
// valid bits and per-stage load enables of the pixel pipeline
module rhsi_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output rhsi_pkg::t_pipe_ctl o_ctl
);
    import rhsi_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_load;

    // a stage may load when empty or when its content moves on
    always_comb begin
        w_load[LAST_STAGE] = !r_valid[LAST_STAGE] || i_out_ready;
        for (int k = LAST_STAGE - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_load[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.load  = w_load;
    assign o_ctl.valid = r_valid;

endmodule

// ----- sv/rgb_to_hsi_pixel_unit.sv -----
// top level of the rgb to hsi pixel converter
// converts one 8-bit blue/green/red pixel per clock, as long as the output is not
// stalled, into hue (degrees/2, 0..180), saturation (0..255) and intensity
// (0..255). the pipeline has 18 register stages: an input stage, 16 cordic
// vectoring stages and an output stage. saturation runs in an 8-step restoring
// divider that shares the cordic stages, intensity is a reciprocal multiply.
// each stage holds its item while the next one is full and cannot move on, so a
// stall on the output side fills the bubbles first and only then pushes back on
// s_axis_tready.
module rgb_to_hsi_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue[7:0], saturation[15:8], intensity[23:16]
);
    import rhsi_pkg::*;

    rhsi_pkg::t_pipe_ctl w_ctl;
    t_stage              r_st [NUM_STAGES];
    t_stage              n_st [NUM_STAGES];

    logic [7:0]  w_b;
    logic [7:0]  w_g;
    logic [7:0]  w_r;
    logic signed [10:0] w_dx;
    logic [7:0]  w_d;
    logic [24:0] w_ymag;
    t_xy         w_x0;
    t_xy         w_y0;

    assign w_b = s_axis_tdata[7:0];
    assign w_g = s_axis_tdata[15:8];
    assign w_r = s_axis_tdata[23:16];

    // 2r-g-b and sqrt(3)*|g-b| span the same angle as the acos form
    assign w_dx   = $signed({2'b00, w_r, 1'b0}) - $signed({3'b000, w_g})
                  - $signed({3'b000, w_b});
    assign w_d    = (w_g > w_b) ? (w_g - w_b) : (w_b - w_g);
    assign w_ymag = w_d * SQRT3_Q16;
    assign w_x0   = {{3{w_dx[10]}}, w_dx, 16'b0};
    assign w_y0   = t_xy'({5'b0, w_ymag});

    rhsi_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    always_comb begin
        t_stage      s;
        logic [9:0]  sum;
        logic [7:0]  mn;
        logic [9:0]  spread;
        logic [25:0] imul;
        t_z          zc;
        logic [25:0] h;
        logic [26:0] hr;
        logic [7:0]  hq;

        // input stage: channel sum, minimum, pre-rotated vector
        s      = '0;
        sum    = {2'b00, w_r} + {2'b00, w_g} + {2'b00, w_b};
        mn     = w_r;
        if (w_g < mn) begin
            mn = w_g;
        end
        if (w_b < mn) begin
            mn = w_b;
        end
        s.sum  = sum;
        s.mn   = mn;
        s.gray = (w_r == w_g) && (w_g == w_b);
        s.bgt  = w_b > w_g;
        if (w_x0 < 0) begin
            // left half plane: turn by -90 degrees first
            s.x = w_y0;
            s.y = -w_x0;
            s.z = Z_90;
        end else begin
            s.x = w_x0;
            s.y = w_y0;
            s.z = '0;
        end
        n_st[0] = s;

        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            s = cordic_step(r_st[k-1], 4'(k - 1));
            if (k == 1) begin
                // divider operands and intensity
                spread  = r_st[0].sum - 10'(3 * r_st[0].mn);
                s.num   = 19'(spread * 19'd510) + {9'b0, r_st[0].sum};
                s.den   = {r_st[0].sum, 1'b0};
                s.rem   = 12'(s.num[18:8]);
                s.quot  = '0;
                imul    = ({r_st[0].sum} + 10'd1) * RECIP3_Q17;
                s.inten = imul[24:17];
            end else if (k >= DIV_FIRST && k < DIV_FIRST + DIV_STEPS) begin
                s = div_step(s, 3'(DIV_FIRST + DIV_STEPS - 1 - k));
            end
            n_st[k] = s;
        end

        // output stage: clamp angle, mirror, halve and round
        s  = r_st[LAST_STAGE-1];
        zc = s.z;
        if (zc < 0) begin
            zc = '0;
        end else if (zc > Z_180) begin
            zc = Z_180;
        end
        h  = s.bgt ? (H_360 - 26'(zc)) : 26'(zc);
        hr = {1'b0, h} + H_HALF;
        hq = hr[24:17];
        if (hr[26:25] != 2'b00 || hq > HUE_MAX) begin
            hq = HUE_MAX;
        end
        s.hue = s.gray ? 8'd0 : hq;
        s.sat = s.gray ? 8'd0 : s.quot;
        n_st[LAST_STAGE] = s;
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_ctl.load[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign s_axis_tready = w_ctl.load[0];
    assign m_axis_tvalid = w_ctl.valid[LAST_STAGE];
    assign m_axis_tdata  = {r_st[LAST_STAGE].inten, r_st[LAST_STAGE].sat,
                            r_st[LAST_STAGE].hue};

endmodule

// ----- sv/rhsi_checker.sv -----
// port-level checks of the rgb to hsi pixel converter
module rhsi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // input back-pressure only when the output is full and stalled
    a_bp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // hue range
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd180)
        else $error("hue above 180");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind rgb_to_hsi_pixel_unit rhsi_checker u_rhsi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/rgb_to_hsi_pixel_checker.sv -----
// checker for the rgb to hsi pixel unit: predicts each result and compares it
module rgb_to_hsi_pixel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] intensity;
        logic [7:0] saturation;
        logic [7:0] hue;
    } t_hsi;

    localparam longint ATAN_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    t_hsi hsi_expected_q[$];

    // hue by cordic vectoring on atan2(sqrt3*|g-b|, 2r-g-b)
    function automatic logic [7:0] hue_angle(input int b, input int g, input int r);
        longint x, y, z, t, dx, dy, h;
        if (r == g && g == b) return 8'd0;
        x = longint'(2 * r - g - b) <<< 16;
        y = longint'((g > b) ? g - b : b - g) * 113512;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 90 <<< 16;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ATAN_DEG[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_DEG[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (180 <<< 16)) z = 180 <<< 16;
        h = (b > g) ? (360 <<< 16) - z : z;
        h = (h + (1 <<< 16)) >>> 17;
        if (h > 180) h = 180;
        return h[7:0];
    endfunction

    function automatic t_hsi convert_pixel(input logic [23:0] pix);
        t_hsi res;
        int   b, g, r, sum, mn, sat, inten;
        b   = pix[7:0];
        g   = pix[15:8];
        r   = pix[23:16];
        sum = r + g + b;
        mn  = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        inten = (sum + 1) / 3;
        if (inten > 255) inten = 255;
        // black pixel gives zero saturation
        sat = 0;
        if (sum != 0) begin
            sat = (510 * (sum - 3 * mn) + sum) / (2 * sum);
            if (sat > 255) sat = 255;
        end
        res.hue        = hue_angle(b, g, r);
        res.saturation = sat[7:0];
        res.intensity  = inten[7:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_hsi got, want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                hsi_expected_q.push_back(convert_pixel(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (hsi_expected_q.size() == 0) begin
                    report_mismatch("unexpected item", got, 0);
                end else begin
                    want = hsi_expected_q.pop_front();
                    if (got.hue != want.hue)
                        report_mismatch("hue", got.hue, want.hue);
                    if (got.saturation != want.saturation)
                        report_mismatch("saturation", got.saturation, want.saturation);
                    if (got.intensity != want.intensity)
                        report_mismatch("intensity", got.intensity, want.intensity);
                end
            end
        end
        o_pending = hsi_expected_q.size();
    end

endmodule

// ----- tb/rgb_to_hsi_pixel_unit_tb.sv -----
// testbench top for the rgb to hsi pixel unit: stimulus and verdict
module rgb_to_hsi_pixel_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // blue[7:0], green[15:8], red[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // hue[7:0], saturation[15:8], intensity[23:16]

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    bit  quiet_phase = 1'b0;   // no idling on either side
    bit  hold_off = 1'b0;      // receiver stalls for a long stretch

    always #5 i_clk = ~i_clk;

    rgb_to_hsi_pixel_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rgb_to_hsi_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls about one cycle in ten, none in the quiet phase
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 10);
    end

    // offer one item, idle beforehand at random, wait until it is taken
    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red);
        while (!quiet_phase && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {red, green, blue};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // random pixel with a bias toward near-gray, extremes and equal channels
    task automatic send_random_pixel();
        logic [7:0] b, g, r;
        int         mode;
        b    = 8'($urandom_range(255));
        g    = 8'($urandom_range(255));
        r    = 8'($urandom_range(255));
        mode = $urandom_range(9);
        case (mode)
            0: begin
                g = b;
            end
            1: begin
                r = 8'(g + 8'($urandom_range(2)));
                b = 8'(g - 8'($urandom_range(2)));
            end
            2: begin
                b = $urandom_range(1) ? 8'd255 : 8'd0;
                g = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            3: begin
                r = b;
            end
            default: ;
        endcase
        send_pixel(b, g, r);
    endtask

    initial begin
        int step;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: black, white, gray, primaries, secondaries, hue wrap points
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd1,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd85,  8'd170, 8'd255);

        // random part with a quiet stretch and a long receiver hold-off
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) quiet_phase = 1'b1;
            if (n == 700) quiet_phase = 1'b0;
            if (n == 1000) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (80) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_random_pixel();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        step = 0;
        while (step < 40) begin
            @(posedge i_clk);
            step++;
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
